@@ hdl/sfr_pkg.sv @@
package sfr_pkg;

  // field widths
  localparam int SAMPLE_W = 24;
  localparam int BIN_W    = 10;
  localparam int GAIN_W   = 16;
  localparam int TAB_W    = 17;
  localparam int SUM_W    = 30;

  // default configuration of the block
  localparam int DEF_WINDOW_SIZE = 1024;
  localparam int DEF_CHANNELS    = 2;
  localparam int DEF_OVERLAP     = 4;

  // queue depths
  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH   = 8;

  // reciprocal shift for bin mod overlap
  localparam int Q_SHIFT = 16;

  // Q28 angle constants for the rotation table
  localparam longint Q28_PI  = 64'sd843314857;
  localparam longint Q28_ONE = 64'sd268435456;

  // taylor series: term count and per-term divisors (2n-1)*2n and 2n*(2n+1)
  localparam int     TAYLOR_TERMS = 14;
  localparam longint COS_DIV [TAYLOR_TERMS] =
    '{2, 12, 30, 56, 90, 132, 182, 240, 306, 380, 462, 552, 650, 756};
  localparam longint SIN_DIV [TAYLOR_TERMS] =
    '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420, 506, 600, 702, 812};

  localparam logic signed [SAMPLE_W-1:0] S24_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] S24_MIN = 24'sh800000;

  typedef struct packed {
    logic                       channel;
    logic [BIN_W-1:0]           bin_index;
    logic signed [SAMPLE_W-1:0] real_in;
    logic signed [SAMPLE_W-1:0] imag_in;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] real_out;
    logic signed [SAMPLE_W-1:0] imag_out;
    logic                       saturated;
  } result_t;

  // classified request between front and back
  typedef struct packed {
    item_t            item;
    logic             ev;    // channel and bin inside the store
    logic [BIN_W-1:0] quot;  // bin_index / overlap
  } qent_t;

  function automatic longint q28_to_q15(input longint v);
    if (v >= 0) begin
      return (v + 64'sd4096) / 64'sd8192;
    end
    return -((-v + 64'sd4096) / 64'sd8192);
  endfunction

  // cos or sin of (x + pi) in Q1.15, x in Q28 with |x| <= pi, by taylor series
  function automatic longint trig_q15(input longint x, input logic want_sin);
    longint x2;
    longint ts;
    longint tc;
    longint ss;
    longint sc;
    x2 = (x * x) / Q28_ONE;
    ts = x;
    tc = Q28_ONE;
    ss = x;
    sc = Q28_ONE;
    for (int n = 0; n < TAYLOR_TERMS; n++) begin
      tc = -((tc * x2) / Q28_ONE) / COS_DIV[n];
      ts = -((ts * x2) / Q28_ONE) / SIN_DIV[n];
      sc += tc;
      ss += ts;
    end
    return want_sin ? q28_to_q15(-ss) : q28_to_q15(-sc);
  endfunction

  // clip flag on top, clipped value below
  function automatic logic [SAMPLE_W:0] sat_s24(input logic signed [SUM_W-1:0] v);
    if (v > SUM_W'(S24_MAX)) begin
      return {1'b1, S24_MAX};
    end
    if (v < SUM_W'(S24_MIN)) begin
      return {1'b1, S24_MIN};
    end
    return {1'b0, v[SAMPLE_W-1:0]};
  endfunction

endpackage

@@ hdl/sfr_fifo.sv @@
module sfr_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [WIDTH-1:0]             wr_data,
  input  logic                         rd_en,
  output logic [WIDTH-1:0]             rd_data,
  output logic [$clog2(DEPTH+1)-1:0]   count,
  output logic                         full,
  output logic                         empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hdl/sfr_front.sv @@
module sfr_front #(
  parameter int WINDOW_SIZE = sfr_pkg::DEF_WINDOW_SIZE,
  parameter int CHANNELS    = sfr_pkg::DEF_CHANNELS,
  parameter int OVERLAP     = sfr_pkg::DEF_OVERLAP
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  sfr_pkg::item_t item,
  input  logic           busy,
  input  logic           q_full,
  output logic           q_push,
  output sfr_pkg::qent_t q_data
);
  import sfr_pkg::*;

  localparam int BINS    = WINDOW_SIZE / 2 + 1;
  localparam int RECIP_W = Q_SHIFT + 1;
  localparam int PROD_W  = BIN_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** Q_SHIFT + OVERLAP - 1) / OVERLAP);

  logic              hold_v;
  qent_t             hold;
  logic              accept;
  logic              ch_ok;
  logic              bin_ok;
  logic [PROD_W-1:0] prod;

  // exact quotient for every 10-bit bin
  assign prod   = PROD_W'(item.bin_index) * PROD_W'(RECIP);
  assign ch_ok  = (32'(item.channel) < 32'(CHANNELS));
  assign bin_ok = (32'(item.bin_index) < 32'(BINS));

  assign q_push = hold_v && !q_full;
  assign full   = busy || (hold_v && q_full);
  assign accept = push && !full;
  assign q_data = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v <= 1'b0;
    end else if (accept) begin
      hold_v <= 1'b1;
    end else if (q_push) begin
      hold_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold.item <= item;
      hold.ev   <= ch_ok && bin_ok;
      hold.quot <= prod[Q_SHIFT +: BIN_W];
    end
  end

endmodule

@@ hdl/sfr_back.sv @@
module sfr_back #(
  parameter int WINDOW_SIZE = sfr_pkg::DEF_WINDOW_SIZE,
  parameter int CHANNELS    = sfr_pkg::DEF_CHANNELS,
  parameter int OVERLAP     = sfr_pkg::DEF_OVERLAP
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [sfr_pkg::GAIN_W-1:0]  gain,
  input  logic                        q_empty,
  input  sfr_pkg::qent_t              q_head,
  output logic                        q_pop,
  output logic                        clearing,
  input  logic                        pop,
  output logic                        empty,
  output sfr_pkg::result_t            result
);
  import sfr_pkg::*;

  localparam int BINS   = WINDOW_SIZE / 2 + 1;
  localparam int DEPTH  = CHANNELS * BINS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int M_W    = (OVERLAP > 1) ? $clog2(OVERLAP) : 1;
  localparam int REM_W  = BIN_W + 5;
  localparam int OCNT_W = $clog2(OUT_DEPTH + 1);
  localparam int PR_W   = SAMPLE_W + TAB_W;
  localparam int ROT_W  = PR_W + 1;
  localparam int FB_W   = ROT_W + GAIN_W + 1;
  localparam int FR_W   = FB_W - 30;

  typedef struct packed {
    logic                       ev;
    logic [ADDR_W-1:0]          addr;
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
  } ctl_t;

  // rotation table
  logic signed [TAB_W-1:0] cos_tab [OVERLAP];
  logic signed [TAB_W-1:0] sin_tab [OVERLAP];

  for (genvar g = 0; g < OVERLAP; g++) begin : g_tab
    localparam longint X = (2 * Q28_PI * longint'(g)) / OVERLAP - Q28_PI;
    localparam logic signed [TAB_W-1:0] COS_V = TAB_W'(trig_q15(X, 1'b0));
    localparam logic signed [TAB_W-1:0] SIN_V = TAB_W'(trig_q15(X, 1'b1));
    assign cos_tab[g] = COS_V;
    assign sin_tab[g] = SIN_V;
  end

  logic [2*SAMPLE_W-1:0] store [DEPTH];
  logic [2*SAMPLE_W-1:0] rdata;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [2*SAMPLE_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]     clear_addr;

  logic [ADDR_W-1:0] head_addr;
  logic [REM_W-1:0]  rem_raw;
  logic [REM_W-1:0]  rem;
  logic [M_W-1:0]    m;
  logic              hazard;
  logic [OCNT_W-1:0] out_count;
  logic [OCNT_W:0]   pending;
  logic              issue;

  logic s1_v, s2_v, s3_v, s4_v;
  ctl_t s1, s2, s3, s4;
  logic signed [TAB_W-1:0] s1_c, s1_s;
  logic signed [PR_W-1:0]  s2_rc, s2_is, s2_rs, s2_ic;
  logic signed [ROT_W-1:0] s3_rot_r, s3_rot_i;
  logic signed [FB_W-1:0]  s4_fb_r, s4_fb_i;

  logic signed [SAMPLE_W-1:0] pr, pim;
  logic signed [FB_W-1:0]     rnd_r, rnd_i;
  logic signed [FR_W-1:0]     fr, fi;
  logic signed [SUM_W-1:0]    sum_r, sum_i;
  logic [SAMPLE_W:0]          sat_r, sat_i;
  result_t                    outcome;

  // issue side
  assign head_addr = ADDR_W'(q_head.item.bin_index)
                   + (q_head.item.channel ? ADDR_W'(BINS) : ADDR_W'(0));
  assign rem_raw   = REM_W'(q_head.item.bin_index) - REM_W'(q_head.quot) * REM_W'(OVERLAP);
  assign rem       = (rem_raw >= REM_W'(OVERLAP)) ? rem_raw - REM_W'(OVERLAP) : rem_raw;
  assign m         = rem[M_W-1:0];

  // a later item of the same entry waits until the earlier write lands
  assign hazard = q_head.ev && (
                    (s1_v && s1.ev && s1.addr == head_addr) ||
                    (s2_v && s2.ev && s2.addr == head_addr) ||
                    (s3_v && s3.ev && s3.addr == head_addr) ||
                    (s4_v && s4.ev && s4.addr == head_addr));

  // room in the result queue for everything in flight
  assign pending = (OCNT_W + 1)'(out_count) + (OCNT_W + 1)'(s1_v) + (OCNT_W + 1)'(s2_v)
                 + (OCNT_W + 1)'(s3_v) + (OCNT_W + 1)'(s4_v);
  assign issue   = !q_empty && !clearing && !hazard && (pending < (OCNT_W + 1)'(OUT_DEPTH));
  assign q_pop   = issue;

  // store, cleared after reset
  assign mem_we    = clearing || (s4_v && s4.ev);
  assign mem_waddr = clearing ? clear_addr : s4.addr;
  assign mem_wdata = clearing ? '0 : {outcome.real_out, outcome.imag_out};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    rdata <= store[head_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      if (clear_addr == ADDR_W'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end else begin
        clear_addr <= clear_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
    end else begin
      s1_v <= issue;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
    end
  end

  assign pr  = rdata[2*SAMPLE_W-1:SAMPLE_W];
  assign pim = rdata[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    s1.ev   <= q_head.ev;
    s1.addr <= head_addr;
    s1.re   <= q_head.item.real_in;
    s1.im   <= q_head.item.imag_in;
    s1_c    <= cos_tab[m];
    s1_s    <= sin_tab[m];

    s2    <= s1;
    s2_rc <= pr * s1_c;
    s2_is <= pim * s1_s;
    s2_rs <= pr * s1_s;
    s2_ic <= pim * s1_c;

    s3       <= s2;
    s3_rot_r <= ROT_W'(s2_rc) - ROT_W'(s2_is);
    s3_rot_i <= ROT_W'(s2_rs) + ROT_W'(s2_ic);

    s4      <= s3;
    s4_fb_r <= s3_rot_r * $signed({1'b0, gain});
    s4_fb_i <= s3_rot_i * $signed({1'b0, gain});
  end

  // round to nearest, halves up, then add and clip
  assign rnd_r = s4_fb_r + FB_W'(64'sh20000000);
  assign rnd_i = s4_fb_i + FB_W'(64'sh20000000);
  assign fr    = rnd_r[FB_W-1:30];
  assign fi    = rnd_i[FB_W-1:30];
  assign sum_r = SUM_W'(s4.re) + SUM_W'(fr);
  assign sum_i = SUM_W'(s4.im) + SUM_W'(fi);
  assign sat_r = sat_s24(sum_r);
  assign sat_i = sat_s24(sum_i);

  always_comb begin
    if (s4.ev) begin
      outcome.real_out  = sat_r[SAMPLE_W-1:0];
      outcome.imag_out  = sat_i[SAMPLE_W-1:0];
      outcome.saturated = sat_r[SAMPLE_W] || sat_i[SAMPLE_W];
    end else begin
      outcome.real_out  = s4.re;
      outcome.imag_out  = s4.im;
      outcome.saturated = 1'b0;
    end
  end

  sfr_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (s4_v),
    .wr_data (outcome),
    .rd_en   (pop && !empty),
    .rd_data (result),
    .count   (out_count),
    .full    (),
    .empty   (empty)
  );

endmodule

@@ hdl/spectral_feedback_reverb.sv @@
// Spectral feedback reverb. Each request is one complex bin (channel, bin_index,
// real_in, imag_in); the block adds the bin it returned for the same channel and bin
// in the previous frame, rotated by bin_index*2*pi/OVERLAP and scaled by
// feedback_gain (unsigned Q1.15, 32768 = 1.0), clips each part to signed 24 bits,
// returns the sum with a saturated flag and keeps it for the next frame. Bins past
// WINDOW_SIZE/2 or channels from CHANNELS up pass through untouched and are not stored.
// Both sides look like queues: push/full in, empty/pop out. One request is taken per
// cycle while full is low; a taken request passes the front's holding register, the
// decoupling queue and pipeline stages s1 to s4 into the result queue. The store is
// one read port and one write port memory of CHANNELS*(WINDOW_SIZE/2+1) words, and
// its read-modify-write spans four pipeline stages, so a request that hits the same
// channel and bin as one of the four before it waits until that write lands. After
// reset a clearing pass zeroes the store, one word a cycle, with full held high;
// feedback_gain may be written meanwhile through cfg_valid/cfg_data, which is
// always ready.
module spectral_feedback_reverb #(
  parameter int WINDOW_SIZE = sfr_pkg::DEF_WINDOW_SIZE,
  parameter int CHANNELS    = sfr_pkg::DEF_CHANNELS,
  parameter int OVERLAP     = sfr_pkg::DEF_OVERLAP
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  sfr_pkg::item_t              item,
  input  logic                        pop,
  output logic                        empty,
  output sfr_pkg::result_t            result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sfr_pkg::GAIN_W-1:0]  cfg_data
);
  import sfr_pkg::*;

  logic [GAIN_W-1:0] gain;
  logic              clearing;

  // front to queue
  logic  q_push;
  qent_t q_in;
  logic  q_full;

  // queue to back
  logic  q_pop;
  qent_t q_head;
  logic  q_empty;

  // gain register, single entry config port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= '0;
    end else if (cfg_valid) begin
      gain <= cfg_data;
    end
  end

  // front: takes requests, checks range, precomputes bin / overlap
  sfr_front #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .CHANNELS    (CHANNELS),
    .OVERLAP     (OVERLAP)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .busy   (clearing),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  // decoupling queue, lets the back stall on a same-entry hazard without
  // holding off the front until the queue fills
  sfr_fifo #(
    .WIDTH ($bits(qent_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_in),
    .rd_en   (q_pop),
    .rd_data (q_head),
    .count   (),
    .full    (q_full),
    .empty   (q_empty)
  );

  // back: store access, rotation, gain, rounding, clip, result queue
  sfr_back #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .CHANNELS    (CHANNELS),
    .OVERLAP     (OVERLAP)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .gain     (gain),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .clearing (clearing),
    .pop      (pop),
    .empty    (empty),
    .result   (result)
  );

endmodule

@@ hdl/sfr_checker.sv @@
module sfr_checker (
  input logic             clk,
  input logic             rst,
  input logic             push,
  input logic             full,
  input logic             pop,
  input logic             empty,
  input sfr_pkg::result_t result
);
  import sfr_pkg::*;

  // requests taken minus results handed out
  logic [5:0] outstanding;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else if ((push && !full) && !(pop && !empty)) begin
      outstanding <= outstanding + 1'b1;
    end else if (!(push && !full) && (pop && !empty)) begin
      outstanding <= outstanding - 1'b1;
    end
  end

  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> full)
    else $error("full low right after reset");

  a_no_invented_result: assert property (@(posedge clk) disable iff (rst)
    !empty |-> outstanding != '0)
    else $error("result shown with no request outstanding");

  a_clip_at_limit: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.saturated) |->
      (result.real_out == S24_MAX || result.real_out == S24_MIN ||
       result.imag_out == S24_MAX || result.imag_out == S24_MIN))
    else $error("saturated flag without a clipped part");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed or vanished");

endmodule

bind spectral_feedback_reverb sfr_checker u_sfr_checker (.*);
